/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge and disabled during reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

/* hdl/c8alu_pkg.sv */
// Package with operation codes, flag positions and shared types of the 8-bit ALU flag unit.
package c8alu_pkg;

   localparam logic [4:0] OP_ORA     = 5'd0;
   localparam logic [4:0] OP_AND     = 5'd1;
   localparam logic [4:0] OP_ADC     = 5'd2;
   localparam logic [4:0] OP_SBC     = 5'd3;
   localparam logic [4:0] OP_BIT     = 5'd4;
   localparam logic [4:0] OP_ASL_ACC = 5'd5;
   localparam logic [4:0] OP_ASL_MEM = 5'd6;
   localparam logic [4:0] OP_INC_MEM = 5'd7;
   localparam logic [4:0] OP_DEC_MEM = 5'd8;
   localparam logic [4:0] OP_LDA     = 5'd9;
   localparam logic [4:0] OP_LDX     = 5'd10;
   localparam logic [4:0] OP_LDY     = 5'd11;
   localparam logic [4:0] OP_TAX     = 5'd12;
   localparam logic [4:0] OP_TXA     = 5'd13;
   localparam logic [4:0] OP_TAY     = 5'd14;
   localparam logic [4:0] OP_TYA     = 5'd15;
   localparam logic [4:0] OP_INX     = 5'd16;
   localparam logic [4:0] OP_DEX     = 5'd17;
   localparam logic [4:0] OP_INY     = 5'd18;
   localparam logic [4:0] OP_DEY     = 5'd19;
   localparam logic [4:0] OP_SETFLAG = 5'd20;
   localparam logic [4:0] OP_PLA     = 5'd21;
   localparam logic [4:0] OP_PLP     = 5'd22;
   localparam logic [4:0] OP_PHA     = 5'd23;
   localparam logic [4:0] OP_PHP     = 5'd24;
   localparam logic [4:0] OP_BRANCH  = 5'd25;

   localparam logic [2:0] FLAG_C = 3'd0;
   localparam logic [2:0] FLAG_Z = 3'd1;
   localparam logic [2:0] FLAG_B = 3'd4;
   localparam logic [2:0] FLAG_U = 3'd5;
   localparam logic [2:0] FLAG_V = 3'd6;
   localparam logic [2:0] FLAG_N = 3'd7;

   localparam logic [7:0] STATUS_RESET = 8'h34;
   localparam logic [7:0] FIXED_BITS   = 8'h30;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] p;
   } regs_type;

   typedef struct packed {
      logic [7:0] mem_data;
      logic       mem_write;
      logic       branch_taken;
   } side_type;

endpackage

/* hdl/c8alu_exec.sv */
// Combinational execute logic: one operation applied to A, X, Y and the status byte.
module c8alu_exec (
   input  c8alu_pkg::regs_type regs_cur,
   input  logic [4:0]          op,
   input  logic [7:0]          operand,
   input  logic [2:0]          flag_sel,
   input  logic                flag_value,
   output c8alu_pkg::regs_type regs_nxt,
   output c8alu_pkg::side_type side
);

   logic [7:0] addend;
   logic [8:0] sum;
   logic [7:0] sum_byte;

   // Update Z and N from a result byte.
   function automatic logic [7:0] with_zn(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r = p;
      r[c8alu_pkg::FLAG_Z] = (v == 8'h00);
      r[c8alu_pkg::FLAG_N] = v[7];
      return r;
   endfunction

   // SBC is ADC of the inverted operand.
   assign addend   = (op == c8alu_pkg::OP_SBC) ? ~operand : operand;
   assign sum      = {1'b0, regs_cur.acc} + {1'b0, addend}
                     + {8'h00, regs_cur.p[c8alu_pkg::FLAG_C]};
   assign sum_byte = sum[7:0];

   always_comb begin
      logic [7:0] tmp;
      regs_nxt          = regs_cur;
      side.mem_data     = 8'h00;
      side.mem_write    = 1'b0;
      side.branch_taken = 1'b0;
      tmp               = 8'h00;
      unique case (op)
         c8alu_pkg::OP_ORA: begin
            tmp          = regs_cur.acc | operand;
            regs_nxt.acc = tmp;
            regs_nxt.p   = with_zn(regs_cur.p, tmp);
         end
         c8alu_pkg::OP_AND: begin
            tmp          = regs_cur.acc & operand;
            regs_nxt.acc = tmp;
            regs_nxt.p   = with_zn(regs_cur.p, tmp);
         end
         c8alu_pkg::OP_ADC, c8alu_pkg::OP_SBC: begin
            regs_nxt.acc                  = sum_byte;
            regs_nxt.p                    = with_zn(regs_cur.p, sum_byte);
            regs_nxt.p[c8alu_pkg::FLAG_C] = sum[8];
            regs_nxt.p[c8alu_pkg::FLAG_V] = (regs_cur.acc[7] ^ sum_byte[7])
                                            & (addend[7] ^ sum_byte[7]);
         end
         c8alu_pkg::OP_BIT: begin
            regs_nxt.p[c8alu_pkg::FLAG_Z] = ((regs_cur.acc & operand) == 8'h00);
            regs_nxt.p[c8alu_pkg::FLAG_V] = operand[6];
            regs_nxt.p[c8alu_pkg::FLAG_N] = operand[7];
         end
         c8alu_pkg::OP_ASL_ACC: begin
            tmp                           = {regs_cur.acc[6:0], 1'b0};
            regs_nxt.acc                  = tmp;
            regs_nxt.p                    = with_zn(regs_cur.p, tmp);
            regs_nxt.p[c8alu_pkg::FLAG_C] = regs_cur.acc[7];
         end
         c8alu_pkg::OP_ASL_MEM: begin
            tmp                           = {operand[6:0], 1'b0};
            regs_nxt.p                    = with_zn(regs_cur.p, tmp);
            regs_nxt.p[c8alu_pkg::FLAG_C] = operand[7];
            side.mem_data                 = tmp;
            side.mem_write                = 1'b1;
         end
         c8alu_pkg::OP_INC_MEM: begin
            tmp            = operand + 8'd1;
            regs_nxt.p     = with_zn(regs_cur.p, tmp);
            side.mem_data  = tmp;
            side.mem_write = 1'b1;
         end
         c8alu_pkg::OP_DEC_MEM: begin
            tmp            = operand - 8'd1;
            regs_nxt.p     = with_zn(regs_cur.p, tmp);
            side.mem_data  = tmp;
            side.mem_write = 1'b1;
         end
         c8alu_pkg::OP_LDA, c8alu_pkg::OP_PLA: begin
            regs_nxt.acc = operand;
            regs_nxt.p   = with_zn(regs_cur.p, operand);
         end
         c8alu_pkg::OP_LDX: begin
            regs_nxt.x = operand;
            regs_nxt.p = with_zn(regs_cur.p, operand);
         end
         c8alu_pkg::OP_LDY: begin
            regs_nxt.y = operand;
            regs_nxt.p = with_zn(regs_cur.p, operand);
         end
         c8alu_pkg::OP_TAX: begin
            regs_nxt.x = regs_cur.acc;
            regs_nxt.p = with_zn(regs_cur.p, regs_cur.acc);
         end
         c8alu_pkg::OP_TXA: begin
            regs_nxt.acc = regs_cur.x;
            regs_nxt.p   = with_zn(regs_cur.p, regs_cur.x);
         end
         c8alu_pkg::OP_TAY: begin
            regs_nxt.y = regs_cur.acc;
            regs_nxt.p = with_zn(regs_cur.p, regs_cur.acc);
         end
         c8alu_pkg::OP_TYA: begin
            regs_nxt.acc = regs_cur.y;
            regs_nxt.p   = with_zn(regs_cur.p, regs_cur.y);
         end
         c8alu_pkg::OP_INX: begin
            tmp        = regs_cur.x + 8'd1;
            regs_nxt.x = tmp;
            regs_nxt.p = with_zn(regs_cur.p, tmp);
         end
         c8alu_pkg::OP_DEX: begin
            tmp        = regs_cur.x - 8'd1;
            regs_nxt.x = tmp;
            regs_nxt.p = with_zn(regs_cur.p, tmp);
         end
         c8alu_pkg::OP_INY: begin
            tmp        = regs_cur.y + 8'd1;
            regs_nxt.y = tmp;
            regs_nxt.p = with_zn(regs_cur.p, tmp);
         end
         c8alu_pkg::OP_DEY: begin
            tmp        = regs_cur.y - 8'd1;
            regs_nxt.y = tmp;
            regs_nxt.p = with_zn(regs_cur.p, tmp);
         end
         c8alu_pkg::OP_SETFLAG: begin
            // The break bit and the fixed bit cannot be written this way.
            if (flag_sel != c8alu_pkg::FLAG_B && flag_sel != c8alu_pkg::FLAG_U) begin
               regs_nxt.p[flag_sel] = flag_value;
            end
         end
         c8alu_pkg::OP_PLP: begin
            regs_nxt.p = (operand & ~c8alu_pkg::FIXED_BITS)
                         | (regs_cur.p & c8alu_pkg::FIXED_BITS);
         end
         c8alu_pkg::OP_PHA: begin
            side.mem_data  = regs_cur.acc;
            side.mem_write = 1'b1;
         end
         c8alu_pkg::OP_PHP: begin
            side.mem_data  = regs_cur.p | c8alu_pkg::FIXED_BITS;
            side.mem_write = 1'b1;
         end
         c8alu_pkg::OP_BRANCH: begin
            side.branch_taken = (regs_cur.p[flag_sel] == flag_value);
         end
         default: begin
         end
      endcase
   end

endmodule

/* hdl/cpu_8bit_alu_flag_unit_top.sv */
// Throughput: one operation per cycle while rsp_ready does not stall the result register;
// the input register, the execute logic and the result register form a two-stage pipe,
// and the register file updates as an item leaves the input register, so the next item
// already sees the new A, X, Y and status byte.
// Reset clears both stage valids, sets A, X and Y to zero and the status byte to 0x34.
module cpu_8bit_alu_flag_unit_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_type,
   input  logic [7:0] req_operand,
   input  logic [2:0] req_flag_sel,
   input  logic       req_flag_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_acc_out,
   output logic [7:0] rsp_x_out,
   output logic [7:0] rsp_y_out,
   output logic [7:0] rsp_status_out,
   output logic [7:0] rsp_mem_data,
   output logic       rsp_mem_write,
   output logic       rsp_branch_taken
);

   logic                in_valid_ff;
   logic [4:0]          op_ff;
   logic [7:0]          operand_ff;
   logic [2:0]          flag_sel_ff;
   logic                flag_value_ff;
   c8alu_pkg::regs_type regs_ff;
   c8alu_pkg::regs_type regs_in;
   c8alu_pkg::side_type side_in;
   c8alu_pkg::side_type side_ff;
   logic                out_valid_ff;
   logic                out_free;
   logic                advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   c8alu_exec u_exec (
      .regs_cur   (regs_ff),
      .op         (op_ff),
      .operand    (operand_ff),
      .flag_sel   (flag_sel_ff),
      .flag_value (flag_value_ff),
      .regs_nxt   (regs_in),
      .side       (side_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff         <= req_type;
         operand_ff    <= req_operand;
         flag_sel_ff   <= req_flag_sel;
         flag_value_ff <= req_flag_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.acc <= 8'h00;
         regs_ff.x   <= 8'h00;
         regs_ff.y   <= 8'h00;
         regs_ff.p   <= c8alu_pkg::STATUS_RESET;
      end else if (advance) begin
         regs_ff <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= side_in;
      end
   end

   // The result register shows the register file as it stood after its own item.
   logic [31:0] shown_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         shown_ff <= regs_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_acc_out      = shown_ff[31:24];
   assign rsp_x_out        = shown_ff[23:16];
   assign rsp_y_out        = shown_ff[15:8];
   assign rsp_status_out   = shown_ff[7:0];
   assign rsp_mem_data     = side_ff.mem_data;
   assign rsp_mem_write    = side_ff.mem_write;
   assign rsp_branch_taken = side_ff.branch_taken;

endmodule

/* hdl/c8alu_checker.sv */
// Port-level checker for the 8-bit ALU flag unit, bound to the top level.
`include "assert_macros.svh"

module c8alu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_acc_out,
   input logic [7:0] rsp_x_out,
   input logic [7:0] rsp_y_out,
   input logic [7:0] rsp_status_out,
   input logic [7:0] rsp_mem_data,
   input logic       rsp_mem_write,
   input logic       rsp_branch_taken
);

   logic [41:0] rsp_payload;
   logic [7:0]  fixed_seen;

   assign rsp_payload = {rsp_acc_out, rsp_x_out, rsp_y_out, rsp_status_out, rsp_mem_data,
                         rsp_mem_write, rsp_branch_taken};
   assign fixed_seen  = rsp_status_out & c8alu_pkg::FIXED_BITS;

   // A stalled result keeps its payload until the transfer.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

   // No result may appear in the cycle after reset.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // The break bit and the fixed bit of the status byte can never be cleared.
   `ASSERT_CLK(a_fixed_bits, clock, reset, rsp_valid |-> fixed_seen == c8alu_pkg::FIXED_BITS)

   // A write-back never comes together with a taken branch.
   `ASSERT_CLK(a_side_excl, clock, reset, rsp_valid |-> !(rsp_mem_write && rsp_branch_taken))

   // Without a write strobe the write-back byte stays zero.
   `ASSERT_CLK(a_mem_idle, clock, reset, rsp_valid && !rsp_mem_write |-> rsp_mem_data == 8'h00)

endmodule

bind cpu_8bit_alu_flag_unit_top c8alu_checker u_c8alu_checker (.*);

/* verif/tb_cpu_8bit_alu_flag_unit_top.sv */
// Self-checking testbench for the 8-bit ALU flag unit, with a predicting scoreboard.
module tb_cpu_8bit_alu_flag_unit_top;

   localparam logic [2:0] FLAG_I = 3'd2;
   localparam logic [2:0] FLAG_D = 3'd3;
   localparam logic [4:0] OP_UNUSED_LO = c8alu_pkg::OP_BRANCH + 5'd1;
   localparam logic [4:0] OP_UNUSED_HI = 5'd31;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned PRINT_LIMIT = 40;

   typedef struct {
      c8alu_pkg::regs_type regs;
      c8alu_pkg::side_type side;
   } alu_outcome_type;

   class alu_flag_scoreboard;
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] p;
      alu_outcome_type pending_results[$];
      int unsigned errors;

      function new();
         acc = 8'h00;
         x = 8'h00;
         y = 8'h00;
         p = c8alu_pkg::STATUS_RESET;
         errors = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function logic [7:0] update_zn(logic [7:0] v);
         p[c8alu_pkg::FLAG_Z] = (v == 8'h00);
         p[c8alu_pkg::FLAG_N] = v[7];
         return v;
      endfunction

      // SBC reuses this with the operand inverted, so carry means no borrow.
      function void add_with_carry(logic [7:0] b);
         logic [8:0] sum;
         logic [7:0] r;
         sum = {1'b0, acc} + {1'b0, b} + {8'h00, p[c8alu_pkg::FLAG_C]};
         r = sum[7:0];
         p[c8alu_pkg::FLAG_C] = sum[8];
         p[c8alu_pkg::FLAG_V] = (acc[7] ^ r[7]) & (b[7] ^ r[7]);
         acc = update_zn(r);
      endfunction

      function logic [7:0] shift_left(logic [7:0] v);
         p[c8alu_pkg::FLAG_C] = v[7];
         return update_zn({v[6:0], 1'b0});
      endfunction

      function void note_input(logic [4:0] op, logic [7:0] operand, logic [2:0] sel,
                               logic fv);
         alu_outcome_type outcome;
         logic [7:0] mdata;
         logic mwr;
         logic taken;
         mdata = 8'h00;
         mwr = 1'b0;
         taken = 1'b0;
         case (op)
            c8alu_pkg::OP_ORA: acc = update_zn(acc | operand);
            c8alu_pkg::OP_AND: acc = update_zn(acc & operand);
            c8alu_pkg::OP_ADC: add_with_carry(operand);
            c8alu_pkg::OP_SBC: add_with_carry(~operand);
            c8alu_pkg::OP_BIT: begin
               p[c8alu_pkg::FLAG_Z] = ((acc & operand) == 8'h00);
               p[c8alu_pkg::FLAG_V] = operand[6];
               p[c8alu_pkg::FLAG_N] = operand[7];
            end
            c8alu_pkg::OP_ASL_ACC: acc = shift_left(acc);
            c8alu_pkg::OP_ASL_MEM: begin
               mdata = shift_left(operand);
               mwr = 1'b1;
            end
            c8alu_pkg::OP_INC_MEM: begin
               mdata = update_zn(operand + 8'h01);
               mwr = 1'b1;
            end
            c8alu_pkg::OP_DEC_MEM: begin
               mdata = update_zn(operand - 8'h01);
               mwr = 1'b1;
            end
            c8alu_pkg::OP_LDA, c8alu_pkg::OP_PLA: acc = update_zn(operand);
            c8alu_pkg::OP_LDX: x = update_zn(operand);
            c8alu_pkg::OP_LDY: y = update_zn(operand);
            c8alu_pkg::OP_TAX: x = update_zn(acc);
            c8alu_pkg::OP_TXA: acc = update_zn(x);
            c8alu_pkg::OP_TAY: y = update_zn(acc);
            c8alu_pkg::OP_TYA: acc = update_zn(y);
            c8alu_pkg::OP_INX: x = update_zn(x + 8'h01);
            c8alu_pkg::OP_DEX: x = update_zn(x - 8'h01);
            c8alu_pkg::OP_INY: y = update_zn(y + 8'h01);
            c8alu_pkg::OP_DEY: y = update_zn(y - 8'h01);
            c8alu_pkg::OP_SETFLAG: begin
               // The break bit and the fixed bit cannot be written this way.
               if (sel != c8alu_pkg::FLAG_B && sel != c8alu_pkg::FLAG_U) begin
                  p[sel] = fv;
               end
            end
            c8alu_pkg::OP_PLP: begin
               p = (operand & ~c8alu_pkg::FIXED_BITS) | (p & c8alu_pkg::FIXED_BITS);
            end
            c8alu_pkg::OP_PHA: begin
               mdata = acc;
               mwr = 1'b1;
            end
            c8alu_pkg::OP_PHP: begin
               mdata = p | c8alu_pkg::FIXED_BITS;
               mwr = 1'b1;
            end
            c8alu_pkg::OP_BRANCH: taken = (p[sel] == fv);
            default: ;
         endcase
         outcome.regs.acc = acc;
         outcome.regs.x = x;
         outcome.regs.y = y;
         outcome.regs.p = p;
         outcome.side.mem_data = mdata;
         outcome.side.mem_write = mwr;
         outcome.side.branch_taken = taken;
         pending_results.push_back(outcome);
      endfunction

      task report_mismatch(string msg);
         if (errors < PRINT_LIMIT) begin
            $display("mismatch: %s", msg);
         end
         errors++;
      endtask

      task check_field(string field, logic [7:0] got, logic [7:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("%s got %h, expected %h", field, got, want));
         end
      endtask

      task check_result(c8alu_pkg::regs_type regs, c8alu_pkg::side_type side);
         alu_outcome_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with no operation outstanding");
         end else begin
            want = pending_results.pop_front();
            check_field("acc_out", regs.acc, want.regs.acc);
            check_field("x_out", regs.x, want.regs.x);
            check_field("y_out", regs.y, want.regs.y);
            check_field("status_out", regs.p, want.regs.p);
            check_field("mem_data", side.mem_data, want.side.mem_data);
            check_field("mem_write", {7'd0, side.mem_write}, {7'd0, want.side.mem_write});
            check_field("branch_taken", {7'd0, side.branch_taken},
                        {7'd0, want.side.branch_taken});
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [4:0] req_type = c8alu_pkg::OP_ORA;
   logic [7:0] req_operand = 8'h00;
   logic [2:0] req_flag_sel = c8alu_pkg::FLAG_C;
   logic req_flag_value = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_acc_out;
   logic [7:0] rsp_x_out;
   logic [7:0] rsp_y_out;
   logic [7:0] rsp_status_out;
   logic [7:0] rsp_mem_data;
   logic rsp_mem_write;
   logic rsp_branch_taken;
   logic quiet = 1'b0;
   int unsigned cycle_count = 0;
   alu_flag_scoreboard sb;

   cpu_8bit_alu_flag_unit_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_operand      (req_operand),
      .req_flag_sel     (req_flag_sel),
      .req_flag_value   (req_flag_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_acc_out      (rsp_acc_out),
      .rsp_x_out        (rsp_x_out),
      .rsp_y_out        (rsp_y_out),
      .rsp_status_out   (rsp_status_out),
      .rsp_mem_data     (rsp_mem_data),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_branch_taken (rsp_branch_taken)
   );

   always #5 clock = ~clock;

   // Mostly no gap, sometimes a short or medium one, rarely a long one.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h7F;
         3: return 8'h80;
         4: return 8'h01;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Both sides sample at the rising edge, so the values seen are the ones before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result('{rsp_acc_out, rsp_x_out, rsp_y_out, rsp_status_out},
                            '{rsp_mem_data, rsp_mem_write, rsp_branch_taken});
         end
         if (req_valid && req_ready) begin
            sb.note_input(req_type, req_operand, req_flag_sel, req_flag_value);
         end
      end
   end

   initial begin
      int unsigned n;
      forever begin
         @(posedge clock);
         n = quiet ? 0 : idle_len();
         if (n == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[cpu_8bit_alu_flag_unit_top] ERROR");
      $finish;
   end

   task automatic send_item(logic [4:0] op, logic [7:0] operand, logic [2:0] sel, logic fv);
      int unsigned gap;
      gap = quiet ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_operand <= operand;
      req_flag_sel <= sel;
      req_flag_value <= fv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random();
      logic [4:0] op;
      if ($urandom_range(0, 99) < 3) begin
         op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else begin
         op = 5'($urandom_range(c8alu_pkg::OP_ORA, c8alu_pkg::OP_BRANCH));
      end
      send_item(op, pick_operand(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
   endtask

   // Holds off the sender until every outstanding transfer has produced its result.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      send_item(c8alu_pkg::OP_LDA, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_LDX, 8'h80, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_LDY, 8'hFF, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_ORA, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_AND, 8'hFF, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_SETFLAG, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_ADC, 8'h7F, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_ADC, 8'h01, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_ADC, 8'h80, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_SBC, 8'h01, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_SBC, 8'h7F, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_BIT, 8'hC0, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_ASL_ACC, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_ASL_MEM, 8'h80, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_INC_MEM, 8'hFF, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_DEC_MEM, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_TAX, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_TXA, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_TAY, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_TYA, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_INX, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_DEX, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_INY, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_DEY, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      // The break bit and the fixed bit must not change through a flag write.
      send_item(c8alu_pkg::OP_SETFLAG, 8'h00, c8alu_pkg::FLAG_B, 1'b0);
      send_item(c8alu_pkg::OP_SETFLAG, 8'h00, c8alu_pkg::FLAG_U, 1'b0);
      send_item(c8alu_pkg::OP_SETFLAG, 8'h00, FLAG_D, 1'b1);
      send_item(c8alu_pkg::OP_SETFLAG, 8'h00, FLAG_I, 1'b0);
      send_item(c8alu_pkg::OP_PLA, 8'h80, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_PLP, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_PHP, 8'hFF, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_PLP, 8'hFF, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_PHA, 8'h00, c8alu_pkg::FLAG_C, 1'b0);
      send_item(c8alu_pkg::OP_BRANCH, 8'h00, c8alu_pkg::FLAG_U, 1'b1);
      send_item(c8alu_pkg::OP_BRANCH, 8'h00, c8alu_pkg::FLAG_B, 1'b0);
      send_item(OP_UNUSED_HI, 8'hFF, c8alu_pkg::FLAG_N, 1'b1);
   endtask

   initial begin
      int unsigned block;
      int unsigned n;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      drain_results();
      for (block = 0; block < 10; block++) begin
         quiet <= ($urandom_range(0, 3) == 0);
         for (n = 0; n < 100; n++) begin
            send_random();
         end
         if ($urandom_range(0, 2) == 0) begin
            drain_results();
         end
      end
      quiet <= 1'b0;
      drain_results();
      repeat (5) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[cpu_8bit_alu_flag_unit_top] OK");
      end else begin
         $display("[cpu_8bit_alu_flag_unit_top] ERROR");
      end
      $finish;
   end

endmodule
